/* hw/rtl/lqrs_pkg.sv */
// Shared constants, types and codes of the linear/quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package lqrs_pkg;
  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int A_BITS    = COEF_BITS - 1;
  localparam int ROOT_BITS = 33;
  localparam int NB_BITS   = COEF_BITS + FRAC_BITS + 1;
  localparam int D_BITS    = 2 * COEF_BITS + 1;
  localparam int S_BITS    = (D_BITS + 1) / 2 + FRAC_BITS;
  localparam int XS_BITS   = 2 * S_BITS;
  localparam int XPAD_BITS = XS_BITS - D_BITS - 2 * FRAC_BITS;
  localparam int NUM_BITS  = S_BITS + 2;
  localparam int DEN_BITS  = A_BITS + 2;
  localparam int SQ_CNT_BITS  = $clog2(S_BITS + 1);
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = QPTR_BITS + 1;

  localparam logic signed [ROOT_BITS-1:0] SAT_HI = {1'b0, {(ROOT_BITS-1){1'b1}}};
  localparam logic signed [ROOT_BITS-1:0] SAT_LO = {1'b1, {(ROOT_BITS-1){1'b0}}};

  typedef enum logic [1:0] {OP_ERR, OP_LIN, OP_QUAD} op_t;

  typedef struct packed {
    op_t                        op;
    logic [A_BITS-1:0]          a;
    logic signed [NB_BITS-1:0]  nb;
    logic                       dneg;
    logic [D_BITS-1:0]          dmag;
  } job_t;

  typedef struct packed {
    logic                        start;
    logic signed [NUM_BITS-1:0]  num;
    logic [DEN_BITS-1:0]         den;
  } div_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [ROOT_BITS-1:0]  q;
  } div_rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/lqrs_front.sv */
// Front end: takes coefficient words, classifies them and forms the discriminant.
`timescale 1ns / 1ps
`default_nettype none
module lqrs_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                take,
  input  wire logic                                kind,
  input  wire logic [lqrs_pkg::A_BITS-1:0]         coef_a,
  input  wire logic signed [lqrs_pkg::COEF_BITS-1:0] coef_b,
  input  wire logic signed [lqrs_pkg::COEF_BITS-1:0] coef_c,
  output logic                                     push,
  output lqrs_pkg::job_t                           job,
  output logic [1:0]                               inflight
);
  logic v1, k1;
  logic [lqrs_pkg::A_BITS-1:0] a1;
  logic signed [lqrs_pkg::COEF_BITS-1:0] b1, c1;

  logic v2, cpos2;
  lqrs_pkg::op_t op2;
  logic [lqrs_pkg::A_BITS-1:0] a2;
  logic signed [lqrs_pkg::NB_BITS-1:0] nb2;
  logic [2*lqrs_pkg::COEF_BITS-1:0] bb2;
  logic [lqrs_pkg::D_BITS-1:0] ac42;

  logic [lqrs_pkg::COEF_BITS-1:0] bmag, cmag;
  logic signed [lqrs_pkg::COEF_BITS:0] negb;
  logic [lqrs_pkg::D_BITS-1:0] bbx;

  assign bmag = b1[lqrs_pkg::COEF_BITS-1] ? lqrs_pkg::COEF_BITS'(-b1) : b1;
  assign cmag = c1[lqrs_pkg::COEF_BITS-1] ? lqrs_pkg::COEF_BITS'(-c1) : c1;
  assign negb = -{b1[lqrs_pkg::COEF_BITS-1], b1};
  assign bbx  = lqrs_pkg::D_BITS'(bb2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
    end
    if (take) begin
      k1 <= kind;
      a1 <= coef_a;
      b1 <= coef_b;
      c1 <= coef_c;
    end
    if (v1) begin
      if (a1 == '0) op2 <= lqrs_pkg::OP_ERR;
      else if (!k1) op2 <= lqrs_pkg::OP_LIN;
      else op2 <= lqrs_pkg::OP_QUAD;
      a2    <= a1;
      nb2   <= {negb, {lqrs_pkg::FRAC_BITS{1'b0}}};
      bb2   <= bmag * bmag;
      ac42  <= {(lqrs_pkg::D_BITS-2)'(a1 * cmag), 2'b00};
      cpos2 <= !c1[lqrs_pkg::COEF_BITS-1] && (c1 != '0);
    end
  end

  always_comb begin
    job.op = op2;
    job.a  = a2;
    job.nb = nb2;
    if (!cpos2) begin
      job.dneg = 1'b0;
      job.dmag = bbx + ac42;
    end else if (bbx >= ac42) begin
      job.dneg = 1'b0;
      job.dmag = bbx - ac42;
    end else begin
      job.dneg = 1'b1;
      job.dmag = ac42 - bbx;
    end
  end

  assign push     = v2;
  assign inflight = {1'b0, v1} + {1'b0, v2};
endmodule
`default_nettype wire

/* hw/rtl/lqrs_sqrt.sv */
// Bit-serial integer square root of the scaled discriminant, one root bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module lqrs_sqrt (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [lqrs_pkg::D_BITS-1:0]       x,
  output logic                                   done,
  output logic [lqrs_pkg::S_BITS-1:0]            root
);
  logic active;
  logic [lqrs_pkg::SQ_CNT_BITS-1:0] cnt;
  logic [lqrs_pkg::XS_BITS-1:0] xs;
  logic [lqrs_pkg::S_BITS:0] rem;
  logic [lqrs_pkg::S_BITS+2:0] rem_sh, trial;

  assign rem_sh = {rem, xs[lqrs_pkg::XS_BITS-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !active) begin
        active <= 1'b1;
        cnt    <= lqrs_pkg::SQ_CNT_BITS'(lqrs_pkg::S_BITS);
        xs     <= {{lqrs_pkg::XPAD_BITS{1'b0}}, x, {(2*lqrs_pkg::FRAC_BITS){1'b0}}};
        rem    <= '0;
        root   <= '0;
      end else if (active) begin
        xs <= xs << 2;
        if (rem_sh >= trial) begin
          rem  <= (lqrs_pkg::S_BITS+1)'(rem_sh - trial);
          root <= {root[lqrs_pkg::S_BITS-2:0], 1'b1};
        end else begin
          rem  <= (lqrs_pkg::S_BITS+1)'(rem_sh);
          root <= {root[lqrs_pkg::S_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == lqrs_pkg::SQ_CNT_BITS'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lqrs_div.sv */
// Restoring divider with round-to-nearest and saturation to the root format.
`timescale 1ns / 1ps
`default_nettype none
module lqrs_div (
  input  wire logic       clk,
  input  wire logic       rst,
  input  lqrs_pkg::div_req_t req,
  output lqrs_pkg::div_rsp_t rsp
);
  logic active, neg, done;
  logic [lqrs_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [lqrs_pkg::NUM_BITS-1:0] n, quo, mag;
  logic [lqrs_pkg::DEN_BITS-1:0] den, rem;
  logic [lqrs_pkg::DEN_BITS:0] rem_sh;
  logic [lqrs_pkg::NUM_BITS-1:0] lim_pos;

  assign mag     = req.num[lqrs_pkg::NUM_BITS-1] ? lqrs_pkg::NUM_BITS'(-req.num) : req.num;
  assign rem_sh  = {rem, n[lqrs_pkg::NUM_BITS-1]};
  assign lim_pos = lqrs_pkg::NUM_BITS'(lqrs_pkg::SAT_HI);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !active) begin
        active <= 1'b1;
        neg    <= req.num[lqrs_pkg::NUM_BITS-1];
        den    <= req.den;
        n      <= mag + lqrs_pkg::NUM_BITS'(req.den >> 1);
        rem    <= '0;
        quo    <= '0;
        cnt    <= lqrs_pkg::DIV_CNT_BITS'(lqrs_pkg::NUM_BITS);
      end else if (active) begin
        n <= n << 1;
        if (rem_sh >= {1'b0, den}) begin
          rem <= lqrs_pkg::DEN_BITS'(rem_sh - {1'b0, den});
          quo <= {quo[lqrs_pkg::NUM_BITS-2:0], 1'b1};
        end else begin
          rem <= lqrs_pkg::DEN_BITS'(rem_sh);
          quo <= {quo[lqrs_pkg::NUM_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == lqrs_pkg::DIV_CNT_BITS'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (neg) begin
      if (quo > lim_pos + 1'b1) rsp.q = lqrs_pkg::SAT_LO;
      else rsp.q = lqrs_pkg::ROOT_BITS'(-quo);
    end else begin
      if (quo > lim_pos) rsp.q = lqrs_pkg::SAT_HI;
      else rsp.q = lqrs_pkg::ROOT_BITS'(quo);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lqrs_back.sv */
// Back end: runs one queued job at a time through the square root and divider as its kind needs, emits roots.
`timescale 1ns / 1ps
`default_nettype none
module lqrs_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  avail,
  input  lqrs_pkg::job_t                             head,
  output logic                                       pop,
  output logic                                       strobe,
  output logic signed [lqrs_pkg::ROOT_BITS-1:0]      root_real,
  output logic signed [lqrs_pkg::ROOT_BITS-1:0]      root_imag,
  output logic                                       status,
  output logic                                       last
);
  typedef enum logic [2:0] {S_IDLE, S_SQRT, S_DIV0, S_DIV1, S_OUT2} state_t;
  state_t state;
  lqrs_pkg::job_t job;
  logic [lqrs_pkg::S_BITS-1:0] s;
  logic signed [lqrs_pkg::ROOT_BITS-1:0] re0, im;
  logic sq_start, sq_done;
  logic [lqrs_pkg::S_BITS-1:0] sq_root;
  lqrs_pkg::div_req_t dreq;
  lqrs_pkg::div_rsp_t drsp;
  logic signed [lqrs_pkg::NUM_BITS-1:0] nbx, sx, rootx;
  logic [lqrs_pkg::DEN_BITS-1:0] den1, den2, hden1;

  lqrs_sqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .x(head.dmag),
                    .done(sq_done), .root(sq_root));
  lqrs_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign pop   = (state == S_IDLE) && avail;
  assign nbx   = lqrs_pkg::NUM_BITS'(job.nb);
  assign sx    = lqrs_pkg::NUM_BITS'(s);
  assign rootx = lqrs_pkg::NUM_BITS'(sq_root);
  assign den1  = lqrs_pkg::DEN_BITS'(head.a);
  assign hden1 = lqrs_pkg::DEN_BITS'(job.a);
  assign den2  = {hden1[lqrs_pkg::DEN_BITS-2:0], 1'b0};
  assign sq_start = pop && (head.op == lqrs_pkg::OP_QUAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      strobe     <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      dreq.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (avail) begin
            job <= head;
            case (head.op)
              lqrs_pkg::OP_ERR: begin
                strobe    <= 1'b1;
                root_real <= '0;
                root_imag <= '0;
                status    <= 1'b1;
                last      <= 1'b1;
              end
              lqrs_pkg::OP_LIN: begin
                dreq.start <= 1'b1;
                dreq.num   <= lqrs_pkg::NUM_BITS'(head.nb);
                dreq.den   <= den1;
                state      <= S_DIV1;
              end
              default: state <= S_SQRT;
            endcase
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            s          <= sq_root;
            dreq.start <= 1'b1;
            dreq.num   <= job.dneg ? nbx : nbx + rootx;
            dreq.den   <= den2;
            state      <= S_DIV0;
          end
        end
        S_DIV0: begin
          if (drsp.done) begin
            if (job.dneg) begin
              re0 <= drsp.q;
            end else begin
              strobe    <= 1'b1;
              root_real <= drsp.q;
              root_imag <= '0;
              status    <= 1'b0;
              last      <= 1'b0;
            end
            dreq.start <= 1'b1;
            dreq.num   <= job.dneg ? sx : nbx - sx;
            dreq.den   <= den2;
            state      <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (drsp.done) begin
            strobe <= 1'b1;
            status <= 1'b0;
            if (job.op == lqrs_pkg::OP_QUAD && job.dneg) begin
              root_real <= re0;
              root_imag <= drsp.q;
              im        <= drsp.q;
              last      <= 1'b0;
              state     <= S_OUT2;
            end else begin
              root_real <= drsp.q;
              root_imag <= '0;
              last      <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        S_OUT2: begin
          strobe    <= 1'b1;
          root_real <= re0;
          root_imag <= -im;
          status    <= 1'b0;
          last      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/linear_quadratic_root_solver.sv */
// Top level of the root solver: front end, job queue and back end.
// An error word is answered without the arithmetic units and a linear word runs one division;
// a quadratic word runs a 33-step square root and two 35-step divisions and yields a real
// pair or a complex pair of root words, each strobed in turn.
// The back end takes a new word only once its last job is through, as the shared bit-serial
// units serve every job; the receiver cannot stall.
// Synchronous reset empties the queue and the pipeline; busy is low right after it.
`timescale 1ns / 1ps
`default_nettype none
module linear_quadratic_root_solver (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  kind,
  input  wire logic [14:0]                           coef_a,
  input  wire logic signed [15:0]                    coef_b,
  input  wire logic signed [15:0]                    coef_c,
  output logic                                       strobe,
  output logic signed [32:0]                         root_real,
  output logic signed [32:0]                         root_imag,
  output logic                                       status,
  output logic                                       last
);
  // The front end never stalls: busy reserves queue room for every word that
  // is still in its two pipeline stages, so each accepted word always lands.
  logic take, push, pop, avail;
  logic [1:0] inflight;
  lqrs_pkg::job_t fjob, head;
  lqrs_pkg::job_t qmem [lqrs_pkg::QDEPTH];
  logic [lqrs_pkg::QPTR_BITS-1:0] wp, rp;
  logic [lqrs_pkg::QCNT_BITS-1:0] cnt;
  logic [lqrs_pkg::QCNT_BITS:0] used;

  assign take  = start && !busy;
  assign used  = {1'b0, cnt} + (lqrs_pkg::QCNT_BITS+1)'(inflight);
  assign busy  = used >= (lqrs_pkg::QCNT_BITS+1)'(lqrs_pkg::QDEPTH);
  assign avail = cnt != '0;
  assign head  = qmem[rp];

  lqrs_front u_front (.clk(clk), .rst(rst), .take(take), .kind(kind), .coef_a(coef_a),
                      .coef_b(coef_b), .coef_c(coef_c), .push(push), .job(fjob),
                      .inflight(inflight));

  // Short queue between the classifier and the solver sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
    if (push) qmem[wp] <= fjob;
  end

  lqrs_back u_back (.clk(clk), .rst(rst), .avail(avail), .head(head), .pop(pop),
                    .strobe(strobe), .root_real(root_real), .root_imag(root_imag),
                    .status(status), .last(last));

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= lqrs_pkg::QCNT_BITS'(lqrs_pkg::QDEPTH)) else $error("queue count overflow");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> cnt < lqrs_pkg::QCNT_BITS'(lqrs_pkg::QDEPTH))
    else $error("word pushed into a full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != '0) else $error("pop from empty queue");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> last) else $error("error result not marked last");
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench of the linear/quadratic root solver.
`timescale 1ns / 1ps
module tb_top;
  localparam logic KIND_LIN  = 1'b0;
  localparam logic KIND_QUAD = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_ZERO_A = 1'b1;
  localparam int   N_RANDOM  = 900;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        kind;
    logic [14:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } coef_word_t;

  typedef struct {
    logic [32:0] re;
    logic [32:0] im;
    logic        st;
    logic        lst;
  } root_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic kind = 1'b0;
  logic [14:0] coef_a = '0;
  logic signed [15:0] coef_b = '0;
  logic signed [15:0] coef_c = '0;
  wire busy, strobe, status, last;
  wire signed [32:0] root_real, root_imag;

  linear_quadratic_root_solver uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c), .strobe(strobe),
    .root_real(root_real), .root_imag(root_imag), .status(status), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  coef_word_t pending_words[$];
  root_word_t expected_roots[$];
  int  mismatches = 0;
  int  idle_pct = 0;
  bit  stim_done = 1'b0;
  longint cycle_count = 0;

  // Exact floor(sqrt(x * 2^32)) by the bit-serial digit method.
  function automatic logic [63:0] scaled_isqrt(input logic [63:0] x);
    logic [63:0] root, rem, trial, pair;
    int k;
    root = 0;
    rem = 0;
    for (int i = 32 + lqrs_pkg::FRAC_BITS - 1; i >= 0; i--) begin
      k = 2 * i - 2 * lqrs_pkg::FRAC_BITS;
      pair = (k >= 0) ? ((x >> k) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Quotient rounded to nearest, ties away from zero, clamped to the root range.
  function automatic logic [32:0] round_div(input longint n, input longint d);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    if (n < 0) return (q > 64'sd4294967296) ? lqrs_pkg::SAT_LO : 33'(-q);
    return (q > 64'sd4294967295) ? lqrs_pkg::SAT_HI : 33'(q);
  endfunction

  task automatic push_root(input logic [32:0] re, input logic [32:0] im,
                           input logic st, input logic lst);
    root_word_t r;
    r.re = re; r.im = im; r.st = st; r.lst = lst;
    expected_roots = {expected_roots, r};
  endtask

  // Works out the roots that one accepted coefficient word must produce.
  task automatic predict_roots(input coef_word_t w);
    longint a, b, c, nb, bb, ac4, dmag, s;
    logic [32:0] re, im;
    bit dneg;
    a = w.a;
    b = longint'(signed'(w.b));
    c = longint'(signed'(w.c));
    nb = -b * 65536;
    if (a == 0) begin
      push_root('0, '0, ST_ZERO_A, 1'b1);
    end else if (w.kind == KIND_LIN) begin
      push_root(round_div(nb, a), '0, ST_OK, 1'b1);
    end else begin
      // The discriminant stays well inside 64 bits at these coefficient widths.
      bb = b * b;
      ac4 = 4 * a * c;
      dneg = (bb - ac4) < 0;
      dmag = dneg ? ac4 - bb : bb - ac4;
      s = longint'(scaled_isqrt(64'(dmag)));
      if (dneg) begin
        re = round_div(nb, 2 * a);
        im = round_div(s, 2 * a);
        push_root(re, im, ST_OK, 1'b0);
        push_root(re, -im, ST_OK, 1'b1);
      end else begin
        push_root(round_div(nb + s, 2 * a), '0, ST_OK, 1'b0);
        push_root(round_div(nb - s, 2 * a), '0, ST_OK, 1'b1);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Driver: start is raised with a word and held until the block takes it, so the
  // accept edge is the one where start is high and busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_roots('{kind, coef_a, coef_b, coef_c});
      if ((!start || !busy) && pending_words.size() > 0 &&
          $urandom_range(99, 0) >= idle_pct) begin
        coef_word_t w;
        w = pending_words.pop_front();
        kind <= w.kind;
        coef_a <= w.a;
        coef_b <= w.b;
        coef_c <= w.c;
        start <= 1'b1;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed root word is compared with the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && strobe) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("root word with nothing expected");
      end else begin
        root_word_t e;
        e = expected_roots.pop_front();
        if (root_real !== e.re)
          report_mismatch($sformatf("root_real %h, want %h", root_real, e.re));
        if (root_imag !== e.im)
          report_mismatch($sformatf("root_imag %h, want %h", root_imag, e.im));
        if (status !== e.st)
          report_mismatch($sformatf("status %b, want %b", status, e.st));
        if (last !== e.lst)
          report_mismatch($sformatf("last %b, want %b", last, e.lst));
      end
    end
  end

  task automatic add_word(input logic k, input logic [14:0] a,
                          input logic [15:0] b, input logic [15:0] c);
    coef_word_t w;
    w.kind = k; w.a = a; w.b = b; w.c = c;
    pending_words = {pending_words, w};
  endtask

  task automatic add_random_word();
    logic [14:0] a;
    logic [15:0] b, c;
    int pick;
    pick = $urandom_range(9, 0);
    a = (pick == 0) ? 15'd0 : (pick < 4) ? 15'($urandom_range(15, 1)) : 15'($urandom);
    b = 16'($urandom);
    c = 16'($urandom);
    // Small coefficients give roots that do not all round to zero or saturate.
    if (pick == 5) begin
      b = 16'($urandom_range(64, 0) - 32);
      c = 16'($urandom_range(64, 0) - 32);
    end
    add_word(1'($urandom), a, b, c);
  endtask

  initial begin
    int phase_pct[4] = '{0, 82, 0, 28};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words: zero leading coefficient for both kinds, field extremes,
    // zero, positive and negative discriminants, and the most negative b and c.
    add_word(KIND_LIN, 15'd0, 16'd5, 16'd3);
    add_word(KIND_QUAD, 15'd0, 16'h8000, 16'h7fff);
    add_word(KIND_LIN, 15'd1, 16'h8000, 16'd0);
    add_word(KIND_LIN, 15'd1, 16'h7fff, 16'hffff);
    add_word(KIND_LIN, 15'h7fff, 16'd1, 16'd0);
    add_word(KIND_LIN, 15'd3, 16'hffff, 16'd0);
    add_word(KIND_LIN, 15'd2, 16'd1, 16'd0);
    add_word(KIND_QUAD, 15'd1, 16'hfffe, 16'd1);
    add_word(KIND_QUAD, 15'd1, 16'd0, 16'd1);
    add_word(KIND_QUAD, 15'd1, 16'hfffd, 16'd2);
    add_word(KIND_QUAD, 15'd1, 16'h8000, 16'h8000);
    add_word(KIND_QUAD, 15'h7fff, 16'h7fff, 16'h7fff);
    add_word(KIND_QUAD, 15'h7fff, 16'h8000, 16'h8000);
    add_word(KIND_QUAD, 15'd1, 16'h0000, 16'h8000);
    add_word(KIND_QUAD, 15'd1, 16'h0000, 16'h7fff);
    add_word(KIND_QUAD, 15'h5555, 16'h5555, 16'haaaa);
    add_word(KIND_QUAD, 15'h2aaa, 16'haaaa, 16'h5555);
    add_word(KIND_QUAD, 15'd3, 16'd7, 16'd0);

    // Random words in phases of different sender idling.
    for (int p = 0; p < 4; p++) begin
      wait (pending_words.size() == 0);
      idle_pct = phase_pct[p];
      for (int i = 0; i < N_RANDOM / 4; i++) add_random_word();
    end
    wait (pending_words.size() == 0 && !start);
    stim_done = 1'b1;
  end

  // End of run: drain the expectations, let the pipeline settle, then judge.
  initial begin
    wait (stim_done);
    while (expected_roots.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // A hung block must not stall the run forever.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end
endmodule

/* linear_quadratic_root_solver.f */
hw/rtl/lqrs_pkg.sv
hw/rtl/lqrs_front.sv
hw/rtl/lqrs_sqrt.sv
hw/rtl/lqrs_div.sv
hw/rtl/lqrs_back.sv
hw/rtl/linear_quadratic_root_solver.sv
test/tb_top.sv
